FILE: rtl/page_frame_type_map_allocator_top_defines.svh
// Assertion macros shared by the page frame type map allocator modules.
`ifndef PAGE_FRAME_TYPE_MAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_TYPE_MAP_ALLOCATOR_TOP_DEFINES_SVH

// Checked property, held off while reset is asserted.
`define PFTA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define PFTA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pfta_pkg.sv
// Types and constants shared by the page frame type map allocator.
package pfta_pkg;

    localparam int CFG_W  = 17;
    localparam int ADDR_W = 32;

    localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET  = 17'd65536;
    localparam logic [CFG_W-1:0] SEARCH_START_RESET = 17'd16384;

    localparam logic [1:0] PAGE_FREE   = 2'd0;
    localparam logic [1:0] PAGE_USER   = 2'd1;
    localparam logic [1:0] PAGE_SYSTEM = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_MARK_SYS = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_UNALIGNED = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    typedef enum logic {
        REG_TOTAL_PAGES  = 1'b0,
        REG_SEARCH_START = 1'b1
    } reg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_step;
        logic alloc_step;
        logic mark_step;
        logic rel_read;
        logic rel_write;
    } pfta_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic walk_end;
        logic alloc_hit;
        logic alloc_miss;
        logic rel_go;
    } pfta_sts_t;

endpackage

FILE: rtl/pfta_ctrl.sv
// Controller state machine that sequences each operation over the page map.
`include "page_frame_type_map_allocator_top_defines.svh"

module pfta_ctrl
    import pfta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] op,
    input  pfta_sts_t sts,
    output pfta_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CLEAR  = 8'b0000_0100,
        S_ALLOC  = 8'b0000_1000,
        S_MARK   = 8'b0001_0000,
        S_REL_RD = 8'b0010_0000,
        S_REL_WR = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (op_t'(op))
                        OP_CLEAR:    state_next = S_CLEAR;
                        OP_ALLOCATE: state_next = S_ALLOC;
                        OP_MARK_SYS: state_next = S_MARK;
                        OP_RELEASE:  state_next = S_REL_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_step = 1'b1;
                if (sts.alloc_hit || sts.alloc_miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_REL_RD:
            begin
                // A release that failed its checks reports without touching the map.
                if (sts.rel_go)
                begin
                    cmd.rel_read = 1'b1;
                    state_next   = S_REL_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REL_WR:
            begin
                cmd.rel_write = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PFTA_ASSERT(a_done_single, done |=> !done, "result strobe held longer than one cycle")
    `PFTA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not make block busy")
    `PFTA_ASSERT_ALWAYS(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command at once")

endmodule

FILE: rtl/pfta_dp.sv
// Datapath: configuration registers, page type memory, walk counter and result registers.
`include "page_frame_type_map_allocator_top_defines.svh"

module pfta_dp
    import pfta_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] byte_address,
    input  logic [ADDR_W-1:0] byte_length,
    input  pfta_cmd_t         cmd,
    output pfta_sts_t         sts,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] page_address
);

    localparam int AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PW  = $clog2(NUM_PAGES + 1);
    localparam int CW  = (PW > CFG_W) ? PW : CFG_W;
    localparam int RW  = ADDR_W + 2 - PAGE_SHIFT;
    localparam int EW  = (RW > CW) ? RW : CW;
    localparam int FW  = ADDR_W - PAGE_SHIFT;
    localparam int LW  = ADDR_W + 1 - PAGE_SHIFT;
    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [CFG_W-1:0] total_pages_reg;
    logic [CFG_W-1:0] search_start_reg;

    logic [EW-1:0] page_reg, page_next;
    logic [EW-1:0] stop_reg, stop_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_page_reg, rd_page_next;
    logic          rel_go_reg, rel_go_next;
    status_t       res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;

    logic [1:0]    page_mem [NUM_PAGES];
    logic [1:0]    rd_data_reg;
    logic          rd_en;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic          waddr_ok;

    logic [CW-1:0] tot_ext;
    logic [EW-1:0] n_valid;
    logic          walk_lt;
    logic          issue;
    logic          hit;
    logic [63:0]   hit_addr;

    logic [FW-1:0] first_page;
    logic [ADDR_W:0] len_round;
    logic [LW-1:0] page_count;
    logic [EW-1:0] range_end;
    logic          aligned;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg  <= TOTAL_PAGES_RESET;
            search_start_reg <= SEARCH_START_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TOTAL_PAGES:  total_pages_reg  <= cfg_data;
                REG_SEARCH_START: search_start_reg <= cfg_data;
                default:          total_pages_reg  <= total_pages_reg;
            endcase
        end
    end

    assign tot_ext = CW'(total_pages_reg);
    assign n_valid = (tot_ext < CW'(NUM_PAGES)) ? EW'(tot_ext) : EW'(NUM_PAGES);

    // Mark-system range and release checks, evaluated when an item is taken.
    assign first_page = byte_address[ADDR_W-1:PAGE_SHIFT];
    assign len_round  = {1'b0, byte_length} + PAGE_MASK;
    assign page_count = len_round[ADDR_W:PAGE_SHIFT];
    assign range_end  = EW'(first_page) + EW'(page_count);
    assign aligned    = (byte_address[PAGE_SHIFT-1:0] == '0);

    assign walk_lt  = (page_reg < stop_reg);
    assign issue    = cmd.alloc_step && walk_lt;
    assign hit      = rd_valid_reg && (rd_data_reg == PAGE_FREE);
    assign hit_addr = 64'(rd_page_reg) << PAGE_SHIFT;

    assign sts.clear_last = (page_reg == EW'(NUM_PAGES - 1));
    assign sts.walk_end   = !walk_lt;
    assign sts.alloc_hit  = hit;
    assign sts.alloc_miss = !rd_valid_reg && !walk_lt;
    assign sts.rel_go     = rel_go_reg;

    always_comb
    begin
        page_next       = page_reg;
        stop_next       = stop_reg;
        rd_valid_next   = rd_valid_reg;
        rd_page_next    = rd_page_reg;
        rel_go_next     = rel_go_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;

        if (cmd.load)
        begin
            page_next       = '0;
            stop_next       = n_valid;
            rd_valid_next   = 1'b0;
            rel_go_next     = 1'b0;
            res_status_next = ST_OK;
            res_addr_next   = '0;
            unique case (op_t'(op))
                OP_CLEAR:
                begin
                    page_next = '0;
                end
                OP_ALLOCATE:
                begin
                    page_next       = EW'(search_start_reg);
                    res_status_next = ST_NONE;
                end
                OP_MARK_SYS:
                begin
                    page_next = EW'(first_page);
                    stop_next = (range_end < n_valid) ? range_end : n_valid;
                    if ((page_count != '0) && (range_end > n_valid))
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
                OP_RELEASE:
                begin
                    page_next = EW'(first_page);
                    if (!aligned)
                    begin
                        res_status_next = ST_UNALIGNED;
                    end
                    else if (EW'(first_page) >= n_valid)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        rel_go_next = 1'b1;
                    end
                end
                default:
                begin
                    page_next = '0;
                end
            endcase
        end
        else
        begin
            if (cmd.clear_step || (cmd.mark_step && walk_lt))
            begin
                page_next = page_reg + EW'(1);
            end
            if (cmd.alloc_step)
            begin
                // One read is issued per cycle; its type is judged in the next cycle.
                rd_valid_next = issue;
                rd_page_next  = page_reg[AW-1:0];
                if (issue)
                begin
                    page_next = page_reg + EW'(1);
                end
                if (hit)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = hit_addr[ADDR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg       <= '0;
            stop_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rd_page_reg    <= '0;
            rel_go_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
        end
        else
        begin
            page_reg       <= page_next;
            stop_reg       <= stop_next;
            rd_valid_reg   <= rd_valid_next;
            rd_page_reg    <= rd_page_next;
            rel_go_reg     <= rel_go_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
        end
    end

    // Page type memory: one write port and one registered read port.
    assign rd_en = issue || cmd.rel_read;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = page_reg[AW-1:0];
        mem_wdata = PAGE_FREE;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.mark_step && walk_lt)
        begin
            mem_we    = 1'b1;
            mem_wdata = PAGE_SYSTEM;
        end
        else if (cmd.alloc_step && hit)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_page_reg;
            mem_wdata = PAGE_USER;
        end
        else if (cmd.rel_write && (rd_data_reg != PAGE_SYSTEM))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= page_mem[page_reg[AW-1:0]];
        end
    end

    assign status       = res_status_reg;
    assign page_address = res_addr_reg;

    assign waddr_ok = (EW'(mem_waddr) < EW'(NUM_PAGES));

    `PFTA_ASSERT(a_waddr_range, mem_we |-> waddr_ok, "page map written beyond its depth")
    `PFTA_ASSERT(a_hit_in_range, (cmd.alloc_step && hit) |-> (EW'(rd_page_reg) < n_valid), "allocated page outside valid pages")
    `PFTA_ASSERT(a_system_kept, (cmd.rel_write && (rd_data_reg == PAGE_SYSTEM)) |-> !mem_we, "release changed a system page")

endmodule

FILE: rtl/page_frame_type_map_allocator_top.sv
// Top level of the page frame type map allocator.
// A command is taken when start is high and busy is low; its single result
// appears on status and page_address while done is high for one cycle, and
// must be taken then. After reset the page map is swept to free at one page
// per cycle with busy high; configuration writes are taken throughout. The
// map is one memory with one write and one registered read port, and every
// walk visits one page per cycle: clear sweeps every page, allocate stops at
// the first free page from the search start, and mark-system walks the pages
// that it marks.
module page_frame_type_map_allocator_top
    import pfta_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] byte_address,
    input  logic [ADDR_W-1:0] byte_length,
    output logic              done,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] page_address
);

    pfta_cmd_t cmd;
    pfta_sts_t sts;

    pfta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pfta_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .byte_address (byte_address),
        .byte_length  (byte_length),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .page_address (page_address)
    );

endmodule

FILE: verif/tb_page_frame_type_map_allocator_top.sv
// Self-checking testbench for the page frame type map allocator top level.
module tb_page_frame_type_map_allocator_top;
    import pfta_pkg::*;

    localparam int NUM_PAGES  = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
    // Clear and the sweep after reset each visit all NUM_PAGES pages.
    localparam int STALL_LIMIT = 300000;

    typedef struct {
        logic        is_reg;
        reg_index_t  reg_sel;
        logic [16:0] reg_value;
        op_t         code;
        logic [31:0] addr;
        logic [31:0] len;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] page_address;
    } outcome_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic              cfg_index    = 1'b0;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              start        = 1'b0;
    logic              busy;
    logic [1:0]        op           = 2'd0;
    logic [ADDR_W-1:0] byte_address = '0;
    logic [ADDR_W-1:0] byte_length  = '0;
    logic              done;
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;

    request_t    pending_q[$];
    outcome_t    outcome_q[$];
    logic [1:0]  type_map [NUM_PAGES];
    logic [16:0] pages_limit = TOTAL_PAGES_RESET;
    logic [16:0] search_from = SEARCH_START_RESET;
    int          gap_cnt;
    bit          steady;
    int          mismatch_count;
    int          stall_cycles;

    page_frame_type_map_allocator_top #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .byte_address (byte_address),
        .byte_length  (byte_length),
        .done         (done),
        .status       (status),
        .page_address (page_address)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        foreach (type_map[i]) type_map[i] = PAGE_FREE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one command to the expected page map and returns its result.
    function automatic outcome_t frame_map_step(op_t code, logic [31:0] addr,
                                                logic [31:0] len);
        outcome_t    res;
        logic [63:0] valid;
        logic [63:0] first;
        logic [63:0] count;
        logic [63:0] last;
        logic [63:0] stop_pg;
        logic [63:0] pg;
        logic [63:0] shifted;
        res.status       = ST_OK;
        res.page_address = '0;
        valid = ({47'd0, pages_limit} < 64'(NUM_PAGES)) ? {47'd0, pages_limit}
                                                         : 64'(NUM_PAGES);
        case (code)
            OP_CLEAR:
            begin
                foreach (type_map[i]) type_map[i] = PAGE_FREE;
            end
            OP_ALLOCATE:
            begin
                res.status = ST_NONE;
                for (pg = {47'd0, search_from}; pg < valid && res.status == ST_NONE; pg++)
                begin
                    if (type_map[pg] == PAGE_FREE)
                    begin
                        type_map[pg]     = PAGE_USER;
                        shifted          = pg << PAGE_SHIFT;
                        res.page_address = shifted[31:0];
                        res.status       = ST_OK;
                    end
                end
            end
            OP_MARK_SYS:
            begin
                first   = {32'd0, addr} >> PAGE_SHIFT;
                count   = ({32'd0, len} + PAGE_MASK) >> PAGE_SHIFT;
                last    = first + count;
                stop_pg = (last < valid) ? last : valid;
                for (pg = first; pg < stop_pg; pg++) type_map[pg] = PAGE_SYSTEM;
                if (count != 0 && last > valid) res.status = ST_RANGE;
            end
            default:
            begin
                pg = {32'd0, addr} >> PAGE_SHIFT;
                if (addr[PAGE_SHIFT-1:0] != '0)
                    res.status = ST_UNALIGNED;
                else if (pg >= valid)
                    res.status = ST_RANGE;
                else if (type_map[pg] != PAGE_SYSTEM)
                    type_map[pg] = PAGE_FREE;
            end
        endcase
        return res;
    endfunction

    task automatic add_op(op_t code, logic [31:0] addr, logic [31:0] len);
        request_t req;
        req.is_reg    = 1'b0;
        req.reg_sel   = REG_TOTAL_PAGES;
        req.reg_value = '0;
        req.code      = code;
        req.addr      = addr;
        req.len       = len;
        pending_q.push_back(req);
    endtask

    task automatic add_reg(reg_index_t sel, logic [16:0] value);
        request_t req;
        req.is_reg    = 1'b1;
        req.reg_sel   = sel;
        req.reg_value = value;
        req.code      = OP_CLEAR;
        req.addr      = '0;
        req.len       = '0;
        pending_q.push_back(req);
    endtask

    // One setting of the registers, a clear, then random commands that stay
    // mostly within span pages from base so that walks remain short.
    task automatic add_random_run(logic [16:0] pages, logic [16:0] from,
                                  int unsigned base, int unsigned span, int count);
        int unsigned pick;
        logic [31:0] addr;
        logic [31:0] len;
        add_reg(REG_TOTAL_PAGES, pages);
        add_reg(REG_SEARCH_START, from);
        add_op(OP_CLEAR, $urandom, $urandom);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            addr = $urandom;
            len  = $urandom;
            if (pick < 40)
            begin
                add_op(OP_ALLOCATE, addr, len);
            end
            else if (pick < 72)
            begin
                if (pick < 68)
                begin
                    addr = (base + $urandom_range(0, span - 1)) << PAGE_SHIFT;
                    if (pick >= 63)
                        addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, 4095));
                end
                add_op(OP_RELEASE, addr, len);
            end
            else
            begin
                if (pick < 92)
                begin
                    addr = ((base + $urandom_range(0, span - 1)) << PAGE_SHIFT)
                           | $urandom_range(0, 4095);
                    if (pick < 88) len = $urandom_range(0, 12288);
                end
                else
                begin
                    len = $urandom_range(0, 32'h3FFFF);
                end
                add_op(OP_MARK_SYS, addr, len);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endtask

    // Driver: one item or register write per step, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        request_t req;
        if (!rst_n)
        begin
            start        <= 1'b0;
            cfg_write    <= 1'b0;
            cfg_index    <= 1'b0;
            cfg_data     <= '0;
            op           <= 2'd0;
            byte_address <= '0;
            byte_length  <= '0;
            gap_cnt = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                outcome_q.push_back(frame_map_step(op_t'(op), byte_address, byte_length));
                if ($urandom_range(0, 15) == 0) steady = !steady;
                gap_cnt = steady ? 0 : $urandom_range(0, 8);
            end
            if (gap_cnt > 0 || pending_q.size() == 0)
            begin
                if (gap_cnt > 0) gap_cnt--;
                start     <= 1'b0;
                cfg_write <= 1'b0;
            end
            else if (pending_q[0].is_reg)
            begin
                start <= 1'b0;
                // Registers change only once every result is back.
                if (outcome_q.size() == 0 && !busy && !done)
                begin
                    req = pending_q.pop_front();
                    cfg_write <= 1'b1;
                    cfg_index <= req.reg_sel;
                    cfg_data  <= req.reg_value;
                    if (req.reg_sel == REG_TOTAL_PAGES)
                        pages_limit = req.reg_value;
                    else
                        search_from = req.reg_value;
                end
                else
                begin
                    cfg_write <= 1'b0;
                end
            end
            else
            begin
                req = pending_q.pop_front();
                cfg_write    <= 1'b0;
                start        <= 1'b1;
                op           <= req.code;
                byte_address <= req.addr;
                byte_length  <= req.len;
            end
        end
    end

    // Monitor: every done cycle carries one result.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with nothing expected: status %0d, address %h",
                             status, page_address);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(status));
                if (page_address !== want.page_address)
                    report_mismatch("page_address", want.page_address, page_address);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("page_frame_type_map_allocator_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [16:0] pages;
        // Directed part at the reset settings.
        add_op(OP_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_RELEASE, 32'h0400_0000, 32'hFFFF_FFFF);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_RELEASE, 32'h0400_0001, 32'h0);
        add_op(OP_RELEASE, 32'hFFFF_F000, 32'h0);
        // Alignment is judged before the range.
        add_op(OP_RELEASE, 32'hFFFF_FFFF, 32'h0);
        add_op(OP_MARK_SYS, 32'h0400_2000, 32'h0);
        add_op(OP_MARK_SYS, 32'h0400_2000, 32'h1);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_RELEASE, 32'h0400_2000, 32'h0);
        add_op(OP_RELEASE, 32'h0500_0000, 32'h0);
        add_op(OP_MARK_SYS, 32'h0FFF_E000, 32'hFFFF_FFFF);
        add_op(OP_MARK_SYS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(OP_MARK_SYS, 32'h0000_0FFF, 32'h0000_1001);
        add_op(OP_RELEASE, 32'h0, 32'h0);
        add_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_reg(REG_SEARCH_START, 17'd0);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_RELEASE, 32'h0, 32'h0);
        add_reg(REG_SEARCH_START, 17'd65535);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_reg(REG_SEARCH_START, 17'd65536);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_reg(REG_TOTAL_PAGES, 17'd0);
        add_reg(REG_SEARCH_START, 17'd0);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);
        add_op(OP_RELEASE, 32'h0, 32'h0);
        add_op(OP_MARK_SYS, 32'h0, 32'h1);
        // A page count above capacity is limited to the map size.
        add_reg(REG_TOTAL_PAGES, 17'h1FFFF);
        add_reg(REG_SEARCH_START, 17'd65535);
        add_op(OP_RELEASE, 32'h0FFF_F000, 32'h0);
        add_op(OP_ALLOCATE, 32'h0, 32'h0);

        // Random part over several settings.
        pages = 17'($urandom_range(16, 96));
        add_random_run(pages, 17'd0, 0, 32'(pages) + 32'd8, 110);
        add_random_run(17'd65536, 17'd65496, 65488, 56, 100);
        add_random_run(17'h1FFFF, 17'd65512, 65504, 40, 90);
        pages = 17'($urandom_range(1, 40));
        add_random_run(pages, 17'($urandom_range(0, pages)), 0, 32'(pages) + 32'd6, 110);
        add_random_run(17'd0, 17'd0, 0, 6, 20);
        add_random_run(17'd20, 17'd4, 0, 26, 90);

        wait (rst_n);
        while (pending_q.size() != 0 || start || outcome_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && outcome_q.size() == 0)
            $display("page_frame_type_map_allocator_top verification clean");
        else
            $display("page_frame_type_map_allocator_top verification failed");
        $finish;
    end

endmodule
